[rtl/core/atd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Affine TRS decomposition package
// Shared widths, types, latencies and constants for the decomposition core.
// ----------------------------------------------------------------------------
package atd_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int NUM_AXES  = 3;

    localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
    localparam int SQ_STEPS  = WORD_BITS;
    localparam int RAD_BITS  = 2 * WORD_BITS;
    localparam int SREM_BITS = WORD_BITS + 4;
    localparam int DREM_BITS = WORD_BITS + 2;
    localparam int DET_BITS  = 3 * WORD_BITS + 4;

    localparam int LANE_LAT  = SQ_STEPS + QUO_BITS + 4;
    localparam int DET_LAT   = 4;
    localparam int FLIP_DLY  = LANE_LAT - DET_LAT;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [WORD_BITS:0]          mag_t;
    typedef logic [QUO_BITS:0]           quo_t;
    typedef logic [1:0]                  axis_t;

    localparam axis_t FIRST_AXIS = 2'd0;
    localparam axis_t LAST_AXIS  = 2'd2;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        mag_t                     mag;
        quo_t  [NUM_AXES-1:0]     quo;
        word_t [NUM_AXES-1:0]     raw;
    } lane_res_t;

endpackage
`default_nettype wire

[rtl/core/atd_det.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Determinant sign unit
// Four-stage pipeline that finds the sign of the exact 3x3 triple product.
// ----------------------------------------------------------------------------
module atd_det (
    input  logic                                   clk,
    input  logic                                   en,
    input  atd_pkg::word_t [atd_pkg::NUM_AXES-1:0] c0,
    input  atd_pkg::word_t [atd_pkg::NUM_AXES-1:0] c1,
    input  atd_pkg::word_t [atd_pkg::NUM_AXES-1:0] c2,
    output logic                                   flip
);
    import atd_pkg::*;

    logic signed [RAD_BITS-1:0]  pv [6];
    logic signed [RAD_BITS-1:0]  pr_reg [6];
    logic signed [RAD_BITS:0]    cof_reg [3];
    logic signed [WORD_BITS:0]   lo_s [3];
    logic signed [WORD_BITS:0]   hi_s [3];
    logic signed [RAD_BITS:0]    plv [3];
    logic signed [RAD_BITS:0]    phv [3];
    logic signed [RAD_BITS:0]    pl_reg [3];
    logic signed [RAD_BITS:0]    ph_reg [3];
    logic signed [DET_BITS-1:0]  hx [3];
    logic signed [DET_BITS-1:0]  lx [3];
    logic signed [DET_BITS-1:0]  tot;
    word_t [NUM_AXES-1:0]        a1_reg;
    word_t [NUM_AXES-1:0]        a2_reg;
    logic                        flip_reg;

    always_comb
    begin
        pv[0] = $signed(c1[1]) * $signed(c2[2]);
        pv[1] = $signed(c1[2]) * $signed(c2[1]);
        pv[2] = $signed(c1[2]) * $signed(c2[0]);
        pv[3] = $signed(c1[0]) * $signed(c2[2]);
        pv[4] = $signed(c1[0]) * $signed(c2[1]);
        pv[5] = $signed(c1[1]) * $signed(c2[0]);
    end

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            lo_s[j] = $signed({1'b0, cof_reg[j][WORD_BITS-1:0]});
            hi_s[j] = $signed(cof_reg[j][RAD_BITS:WORD_BITS]);
            plv[j]  = $signed(a2_reg[j]) * lo_s[j];
            phv[j]  = $signed(a2_reg[j]) * hi_s[j];
            hx[j]   = ph_reg[j];
            lx[j]   = pl_reg[j];
        end
        tot = (hx[0] <<< WORD_BITS) + lx[0] + (hx[1] <<< WORD_BITS) + lx[1]
            + (hx[2] <<< WORD_BITS) + lx[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 6; i++)
            begin
                pr_reg[i] <= pv[i];
            end
            a1_reg <= c0;
            a2_reg <= a1_reg;
            for (int j = 0; j < 3; j++)
            begin
                cof_reg[j] <= (RAD_BITS+1)'(pr_reg[2*j]) - (RAD_BITS+1)'(pr_reg[2*j+1]);
                pl_reg[j]  <= plv[j];
                ph_reg[j]  <= phv[j];
            end
            flip_reg <= tot[DET_BITS-1];
        end
    end

    assign flip = flip_reg;

endmodule
`default_nettype wire

[rtl/core/atd_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Axis lane
// Pipelined column length (digit-by-digit square root) and three pipelined
// restoring dividers that normalize the column by that length.
// ----------------------------------------------------------------------------
module atd_lane (
    input  logic                                   clk,
    input  logic                                   en,
    input  atd_pkg::word_t [atd_pkg::NUM_AXES-1:0] col,
    output atd_pkg::lane_res_t                     res
);
    import atd_pkg::*;

    word_t [NUM_AXES-1:0]       col_d [LANE_LAT];
    logic signed [RAD_BITS-1:0] sqv [3];
    logic [RAD_BITS-1:0]        sq_reg [3];
    logic [RAD_BITS-1:0]        rad_reg [SQ_STEPS+1];
    logic [SREM_BITS-1:0]       srem_reg [SQ_STEPS+1];
    logic [WORD_BITS-1:0]       root_reg [SQ_STEPS+1];
    logic [WORD_BITS-1:0]       absv [3];
    mag_t                       dmag_reg [QUO_BITS+1];
    logic [QUO_BITS-1:0]        num_reg [QUO_BITS+1][3];
    logic [DREM_BITS-1:0]       drem_reg [QUO_BITS+1][3];
    logic [QUO_BITS-1:0]        q_reg [QUO_BITS+1][3];
    mag_t                       mag_out_reg;
    quo_t [NUM_AXES-1:0]        quo_out_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sqv[j] = $signed(col[j]) * $signed(col[j]);
            if (col_d[SQ_STEPS+1][j][WORD_BITS-1])
            begin
                absv[j] = WORD_BITS'(~col_d[SQ_STEPS+1][j] + 1'b1);
            end
            else
            begin
                absv[j] = WORD_BITS'(col_d[SQ_STEPS+1][j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_d[0] <= col;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                col_d[i] <= col_d[i-1];
            end
            for (int j = 0; j < 3; j++)
            begin
                sq_reg[j] <= RAD_BITS'(sqv[j]);
            end
            rad_reg[0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            srem_reg[0] <= '0;
            root_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_sqrt
        logic [SREM_BITS-1:0] rin;
        logic [SREM_BITS-1:0] trial;

        always_comb
        begin
            rin   = {srem_reg[k][SREM_BITS-3:0], rad_reg[k][RAD_BITS-1 -: 2]};
            trial = SREM_BITS'({root_reg[k], 2'b01});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k+1] <= {rad_reg[k][RAD_BITS-3:0], 2'b00};
                if (rin >= trial)
                begin
                    srem_reg[k+1] <= rin - trial;
                    root_reg[k+1] <= {root_reg[k][WORD_BITS-2:0], 1'b1};
                end
                else
                begin
                    srem_reg[k+1] <= rin;
                    root_reg[k+1] <= {root_reg[k][WORD_BITS-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dmag_reg[0] <= {1'b0, root_reg[SQ_STEPS]}
                         + mag_t'(srem_reg[SQ_STEPS] > SREM_BITS'(root_reg[SQ_STEPS]));
            for (int j = 0; j < 3; j++)
            begin
                num_reg[0][j]  <= {absv[j], {FRAC_BITS{1'b0}}};
                drem_reg[0][j] <= '0;
                q_reg[0][j]    <= '0;
            end
        end
    end

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dmag_reg[i+1] <= dmag_reg[i];
            end
        end

        for (genvar j = 0; j < 3; j++)
        begin : g_comp
            logic [DREM_BITS-1:0] rin;
            logic [DREM_BITS-1:0] dv;

            always_comb
            begin
                rin = {drem_reg[i][j][DREM_BITS-2:0], num_reg[i][j][QUO_BITS-1]};
                dv  = DREM_BITS'(dmag_reg[i]);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    num_reg[i+1][j] <= {num_reg[i][j][QUO_BITS-2:0], 1'b0};
                    if (rin >= dv)
                    begin
                        drem_reg[i+1][j] <= rin - dv;
                        q_reg[i+1][j]    <= {q_reg[i][j][QUO_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg[i+1][j] <= rin;
                        q_reg[i+1][j]    <= {q_reg[i][j][QUO_BITS-2:0], 1'b0};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_out_reg <= dmag_reg[QUO_BITS];
            for (int j = 0; j < 3; j++)
            begin
                quo_out_reg[j] <= {1'b0, q_reg[QUO_BITS][j]}
                    + quo_t'({drem_reg[QUO_BITS][j], 1'b0}
                             >= (DREM_BITS+1)'(dmag_reg[QUO_BITS]));
            end
        end
    end

    assign res.mag = mag_out_reg;
    assign res.quo = quo_out_reg;
    assign res.raw = col_d[LANE_LAT-1];

endmodule
`default_nettype wire

[rtl/core/atd_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Result merge stage
// Applies the determinant sign and saturation to the lane results and sends
// the three axis results of one matrix out one transfer at a time.
// ----------------------------------------------------------------------------
module atd_merge (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  atd_pkg::lane_res_t [atd_pkg::NUM_AXES-1:0] lres,
    input  logic                                       flip,
    input  atd_pkg::word_t [atd_pkg::NUM_AXES-1:0]     move,
    input  logic                                       ld_valid,
    output logic                                       ser_free,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output atd_pkg::axis_t                             axis,
    output atd_pkg::word_t                             scale,
    output atd_pkg::word_t                             rot_x,
    output atd_pkg::word_t                             rot_y,
    output atd_pkg::word_t                             rot_z,
    output atd_pkg::word_t                             shift,
    output logic                                       last
);
    import atd_pkg::*;

    typedef struct packed {
        word_t                scale;
        word_t [NUM_AXES-1:0] rot;
        word_t                shift;
    } result_t;

    function automatic word_t sat_val(input quo_t m, input logic neg);
        quo_t lim;
        lim = quo_t'(1) << (WORD_BITS - 1);
        if (neg)
        begin
            if (m > lim)
            begin
                sat_val = WORD_MIN;
            end
            else
            begin
                sat_val = word_t'(~m[WORD_BITS-1:0] + 1'b1);
            end
        end
        else if (m >= lim)
        begin
            sat_val = WORD_MAX;
        end
        else
        begin
            sat_val = word_t'(m[WORD_BITS-1:0]);
        end
    endfunction

    result_t res_next [NUM_AXES];
    result_t res_reg [NUM_AXES];
    result_t cur;
    logic    busy_reg;
    axis_t   cnt_reg;
    logic    load;

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            res_next[k].scale = sat_val(quo_t'(lres[k].mag), flip);
            for (int j = 0; j < NUM_AXES; j++)
            begin
                if (lres[k].mag == '0)
                begin
                    res_next[k].rot[j] = lres[k].raw[j];
                end
                else
                begin
                    res_next[k].rot[j] = sat_val(lres[k].quo[j],
                                                 lres[k].raw[j][WORD_BITS-1] ^ flip);
                end
            end
            res_next[k].shift = move[k];
        end
    end

    assign ser_free = !busy_reg || ((cnt_reg == LAST_AXIS) && !out_stall);
    assign load     = ld_valid && ser_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= FIRST_AXIS;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= FIRST_AXIS;
        end
        else if (busy_reg && !out_stall)
        begin
            if (cnt_reg == LAST_AXIS)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                res_reg[k] <= res_next[k];
            end
        end
    end

    always_comb
    begin
        unique case (cnt_reg)
            2'd0:    cur = res_reg[0];
            2'd1:    cur = res_reg[1];
            default: cur = res_reg[2];
        endcase
    end

    assign out_valid = busy_reg;
    assign axis      = cnt_reg;
    assign scale     = cur.scale;
    assign rot_x     = cur.rot[0];
    assign rot_y     = cur.rot[1];
    assign rot_z     = cur.rot[2];
    assign shift     = cur.shift;
    assign last      = (cnt_reg == LAST_AXIS);

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= LAST_AXIS))
        else $error("axis counter out of range");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_stall && (cnt_reg != LAST_AXIS)) |=>
        (busy_reg && (cnt_reg == $past(cnt_reg) + 2'd1)))
        else $error("axis sequence broken");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_stall) |=> (busy_reg && $stable(cnt_reg)))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire

[rtl/core/affine_trs_decompose.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Affine TRS decomposition, top level
// One transfer on the input channel carries an affine transform as three
// basis columns and a translation column, each word signed Q16.16. Three
// lanes, one per basis column, compute the column length with a pipelined
// square root and divide the column by it in pipelined dividers, while a
// separate unit finds the determinant sign. A merge stage applies the sign,
// saturates, and sends three result transfers per matrix, axis 0 to 2, with
// last set on axis 2.
// The lane pipelines hold the 32 square-root steps and the 48 divider steps.
// The pipeline can take a new matrix while earlier ones are still in it;
// the output channel sends three result transfers per matrix. When the
// receiver stalls or the merge stage is still sending a matrix, the pipeline
// holds once its last stage is full and in_stall rises; a new matrix is
// taken while the last result of the previous one goes out. Reset empties
// the pipeline and the output stage.
// ----------------------------------------------------------------------------
module affine_trs_decompose (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  atd_pkg::word_t col0_x,
    input  atd_pkg::word_t col0_y,
    input  atd_pkg::word_t col0_z,
    input  atd_pkg::word_t col1_x,
    input  atd_pkg::word_t col1_y,
    input  atd_pkg::word_t col1_z,
    input  atd_pkg::word_t col2_x,
    input  atd_pkg::word_t col2_y,
    input  atd_pkg::word_t col2_z,
    input  atd_pkg::word_t move_x,
    input  atd_pkg::word_t move_y,
    input  atd_pkg::word_t move_z,
    output logic           out_valid,
    input  logic           out_stall,
    output atd_pkg::axis_t axis,
    output atd_pkg::word_t scale,
    output atd_pkg::word_t rot_x,
    output atd_pkg::word_t rot_y,
    output atd_pkg::word_t rot_z,
    output atd_pkg::word_t shift,
    output logic           last
);
    import atd_pkg::*;

    word_t [NUM_AXES-1:0]     colv [NUM_AXES];
    word_t [NUM_AXES-1:0]     move_in;
    word_t [NUM_AXES-1:0]     move_d [LANE_LAT];
    lane_res_t [NUM_AXES-1:0] lres;
    logic [LANE_LAT-1:0]      vld_reg;
    logic [FLIP_DLY-1:0]      flip_d;
    logic                     det_flip;
    logic                     ser_free;
    logic                     adv;

    assign colv[0] = {col0_z, col0_y, col0_x};
    assign colv[1] = {col1_z, col1_y, col1_x};
    assign colv[2] = {col2_z, col2_y, col2_x};
    assign move_in = {move_z, move_y, move_x};

    assign adv      = !vld_reg[LANE_LAT-1] || ser_free;
    assign in_stall = !adv;

    atd_det u_det (
        .clk  (clk),
        .en   (adv),
        .c0   (colv[0]),
        .c1   (colv[1]),
        .c2   (colv[2]),
        .flip (det_flip)
    );

    for (genvar k = 0; k < NUM_AXES; k++)
    begin : g_lane
        atd_lane u_lane (
            .clk (clk),
            .en  (adv),
            .col (colv[k]),
            .res (lres[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LANE_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            move_d[0] <= move_in;
            for (int i = 1; i < LANE_LAT; i++)
            begin
                move_d[i] <= move_d[i-1];
            end
            flip_d <= {flip_d[FLIP_DLY-2:0], det_flip};
        end
    end

    atd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lres      (lres),
        .flip      (flip_d[FLIP_DLY-1]),
        .move      (move_d[LANE_LAT-1]),
        .ld_valid  (vld_reg[LANE_LAT-1]),
        .ser_free  (ser_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .axis      (axis),
        .scale     (scale),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .shift     (shift),
        .last      (last)
    );

`ifndef SYNTH
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");
`endif

endmodule
`default_nettype wire
